// File: hdl/joystick_trim_calibrate_macros.svh
// Assertion macros used by the jtc_merge stage of the joystick conditioning RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef JOYSTICK_TRIM_CALIBRATE_MACROS_SVH
`define JOYSTICK_TRIM_CALIBRATE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define JTC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define JTC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: hdl/jtc_pkg.sv
// Shared types and constants for the joystick trim and calibration block.
// No dependencies; used by the interfaces, lanes, merge stage and top level.
package jtc_pkg;

  localparam int SCALE_MAX = 1000;
  localparam int CENTER    = 500;
  localparam int LIMIT     = 1000;

  localparam int VAL_W  = 10;
  localparam int OFF_W  = 12;
  localparam int TRIM_W = 12;
  localparam int STEP_W = 7;
  localparam int KEY_W  = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = 7'd10;

  localparam int NUM_LANES = 4;
  localparam int LANE_THR  = 0;
  localparam int LANE_YAW  = 1;
  localparam int LANE_PIT  = 2;
  localparam int LANE_ROL  = 3;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TRIM_STEP = 1'b0;

  localparam logic REQ_KEY = 1'b1;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE    = 3'd0,
    KEY_UP      = 3'd1,
    KEY_DN      = 3'd2,
    KEY_LT      = 3'd3,
    KEY_RT      = 3'd4,
    KEY_LX      = 3'd5,
    KEY_RX      = 3'd6,
    KEY_RX_LONG = 3'd7
  } key_code_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic accum;
    logic clear;
    logic fin1;
    logic fin2;
  } lane_ctl_t;

endpackage

// File: hdl/jtc_in_if.sv
// Request channel carrying stick samples and key events.
// Depends on jtc_pkg for the key code width.
interface jtc_in_if #(
  parameter int ADC_BITS = 12
) ();
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ADC_BITS-1:0]         adc_throttle;
  logic [ADC_BITS-1:0]         adc_yaw;
  logic [ADC_BITS-1:0]         adc_pitch;
  logic [ADC_BITS-1:0]         adc_roll;
  logic [jtc_pkg::KEY_W-1:0]   key_code;

  modport source (
    output valid, req_type, adc_throttle, adc_yaw, adc_pitch, adc_roll, key_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, adc_throttle, adc_yaw, adc_pitch, adc_roll, key_code,
    output ready
  );
endinterface

// File: hdl/jtc_out_if.sv
// Result channel carrying the conditioned stick values and status flags.
// Depends on jtc_pkg for the value width.
interface jtc_out_if ();
  logic                      valid;
  logic                      ready;
  logic [jtc_pkg::VAL_W-1:0] throttle_out;
  logic [jtc_pkg::VAL_W-1:0] yaw_out;
  logic [jtc_pkg::VAL_W-1:0] pitch_out;
  logic [jtc_pkg::VAL_W-1:0] roll_out;
  logic                      shutdown_flag;
  logic                      hold_height_flag;
  logic                      calibrating;

  modport source (
    output valid, throttle_out, yaw_out, pitch_out, roll_out,
           shutdown_flag, hold_height_flag, calibrating,
    input  ready
  );
  modport sink (
    input  valid, throttle_out, yaw_out, pitch_out, roll_out,
           shutdown_flag, hold_height_flag, calibrating,
    output ready
  );
endinterface

// File: hdl/jtc_lane.sv
// One stick channel: scaling pipeline, offset and trim, zero-offset calibration.
// Depends on jtc_pkg; controlled by jtc_merge through a lane_ctl_t bundle.
module jtc_lane #(
  parameter int ADC_BITS    = 12,
  parameter int CAL_SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  jtc_pkg::lane_ctl_t                 ctl,
  input  logic                               center_en,
  input  logic [ADC_BITS-1:0]                adc,
  input  logic signed [jtc_pkg::TRIM_W-1:0]  trim,
  output logic [jtc_pkg::VAL_W-1:0]          val
);

  localparam int VW   = jtc_pkg::VAL_W;
  localparam int XW   = ADC_BITS + 10;
  localparam int DIV  = (1 << ADC_BITS) - 1;
  localparam int SS   = XW + ADC_BITS;
  localparam logic [63:0] SM = ((64'd1 << SS) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam int SMW  = XW + 1;
  localparam int PW   = XW + SMW;

  localparam int MAGW = $clog2(CAL_SAMPLES * jtc_pkg::SCALE_MAX + 1);
  localparam int SUMW = MAGW + 1;
  localparam int CS   = MAGW + $clog2(CAL_SAMPLES);
  localparam logic [63:0] CM =
    ((64'd1 << CS) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam int CMW  = MAGW + 1;
  localparam int CPW  = MAGW + CMW;

  localparam int SVW  = 14;

  logic [XW-1:0]                 prod_r;
  logic [VW-1:0]                 scl_r;
  logic signed [jtc_pkg::OFF_W-1:0] off_r;
  logic signed [SUMW-1:0]        sum_r;
  logic [VW-1:0]                 q_r;
  logic                          neg_r;

  logic [XW-1:0]                 prod_nxt;
  logic [PW-1:0]                 sprod;
  logic [VW-1:0]                 scl_nxt;
  logic signed [SVW-1:0]         sv;
  logic signed [SUMW-1:0]        dev;
  logic [MAGW-1:0]               mag;
  logic [CPW-1:0]                cprod;
  logic signed [SVW-1:0]         qs;
  logic signed [SVW-1:0]         onew;
  logic signed [jtc_pkg::OFF_W-1:0] off_nxt;

  always_comb begin
    prod_nxt = XW'(adc) * XW'(jtc_pkg::SCALE_MAX);
    sprod    = PW'(prod_r) * PW'(SM[SMW-1:0]);
    scl_nxt  = VW'(jtc_pkg::SCALE_MAX) - sprod[SS +: VW];
  end

  always_comb begin
    sv = $signed({4'b0, scl_r}) - SVW'(off_r) + SVW'(trim);
    if (sv < 0) begin
      val = '0;
    end else if (sv > SVW'(jtc_pkg::SCALE_MAX)) begin
      val = VW'(jtc_pkg::SCALE_MAX);
    end else begin
      val = sv[VW-1:0];
    end
    dev = SUMW'($signed({1'b0, val})) - (center_en ? SUMW'(jtc_pkg::CENTER) : '0);
  end

  always_comb begin
    mag   = sum_r[SUMW-1] ? MAGW'(-sum_r) : MAGW'(sum_r);
    cprod = CPW'(mag) * CPW'(CM[CMW-1:0]);
    qs    = SVW'($signed({1'b0, q_r}));
    onew  = SVW'(off_r) + (neg_r ? -qs : qs);
    if (onew > SVW'(jtc_pkg::LIMIT)) begin
      off_nxt = jtc_pkg::OFF_W'(jtc_pkg::LIMIT);
    end else if (onew < -SVW'(jtc_pkg::LIMIT)) begin
      off_nxt = -jtc_pkg::OFF_W'(jtc_pkg::LIMIT);
    end else begin
      off_nxt = onew[jtc_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      prod_r <= prod_nxt;
    end
    if (ctl.ld2) begin
      scl_r <= scl_nxt;
    end
    if (ctl.fin1) begin
      q_r   <= cprod[CS +: VW];
      neg_r <= sum_r[SUMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      sum_r <= '0;
    end else begin
      if (ctl.clear || ctl.fin2) begin
        sum_r <= '0;
      end else if (ctl.accum) begin
        sum_r <= sum_r + dev;
      end
      if (ctl.fin2) begin
        off_r <= off_nxt;
      end
    end
  end

endmodule

// File: hdl/jtc_merge.sv
// Item pipeline control, key handling, calibration sequencing and result register.
// Depends on jtc_pkg, jtc_in_if, jtc_out_if and the assertion macro header.
`include "joystick_trim_calibrate_macros.svh"

module jtc_merge #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  jtc_in_if.sink                            in_chan,
  jtc_out_if.source                         out_chan,
  input  logic [jtc_pkg::STEP_W-1:0]        trim_step,
  input  logic [jtc_pkg::VAL_W-1:0]         lane_val [jtc_pkg::NUM_LANES],
  output jtc_pkg::lane_ctl_t                ctl,
  output logic signed [jtc_pkg::TRIM_W-1:0] pitch_trim,
  output logic signed [jtc_pkg::TRIM_W-1:0] roll_trim
);

  localparam int CW = $clog2(CAL_SAMPLES + 1);
  localparam int TW = jtc_pkg::TRIM_W;

  logic                   p1_v_r, p2_v_r;
  logic                   p1_key_r, p2_key_r;
  jtc_pkg::key_code_t     p1_code_r, p2_code_r;
  logic                   out_v_r;
  logic [jtc_pkg::VAL_W-1:0] out_val_r [jtc_pkg::NUM_LANES];
  logic                   out_shut_r, out_hold_r, out_cal_r;
  logic signed [TW-1:0]   pitch_r, roll_r;
  logic signed [TW-1:0]   pitch_nxt, roll_nxt;
  logic                   shut_r, hold_r, cal_r;
  logic                   shut_nxt, hold_nxt, cal_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   fin1_r, fin2_r;

  logic                   busy, proc, smp, kp, last, ld1, ld2, in_ready;
  logic signed [TW:0]     stp;
  logic                   trim_ok;

  function automatic logic signed [TW-1:0] trim_sat(input logic signed [TW:0] x);
    if (x > (TW+1)'(jtc_pkg::LIMIT)) begin
      return TW'(jtc_pkg::LIMIT);
    end else if (x < -(TW+1)'(jtc_pkg::LIMIT)) begin
      return -TW'(jtc_pkg::LIMIT);
    end
    return x[TW-1:0];
  endfunction

  always_comb begin
    busy     = fin1_r || fin2_r;
    proc     = p2_v_r && !busy && (p2_key_r || !out_v_r || out_chan.ready);
    smp      = proc && !p2_key_r;
    kp       = proc && p2_key_r && !cal_r;
    last     = smp && cal_r && (cnt_r == CW'(CAL_SAMPLES - 1));
    ld2      = p1_v_r && (!p2_v_r || proc);
    in_ready = !p1_v_r || ld2;
    ld1      = in_chan.valid && in_ready;
    stp      = $signed({{(TW + 1 - jtc_pkg::STEP_W){1'b0}}, trim_step});
  end

  always_comb begin
    ctl.ld1   = ld1;
    ctl.ld2   = ld2;
    ctl.accum = smp && cal_r;
    ctl.clear = kp && (p2_code_r == jtc_pkg::KEY_RX_LONG);
    ctl.fin1  = fin1_r;
    ctl.fin2  = fin2_r;
  end

  always_comb begin
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    shut_nxt  = shut_r;
    hold_nxt  = hold_r;
    cal_nxt   = cal_r;
    cnt_nxt   = cnt_r;
    if (kp) begin
      unique case (p2_code_r)
        jtc_pkg::KEY_NONE:  ;
        jtc_pkg::KEY_UP:    pitch_nxt = trim_sat((TW+1)'(pitch_r) + stp);
        jtc_pkg::KEY_DN:    pitch_nxt = trim_sat((TW+1)'(pitch_r) - stp);
        jtc_pkg::KEY_LT:    roll_nxt  = trim_sat((TW+1)'(roll_r) - stp);
        jtc_pkg::KEY_RT:    roll_nxt  = trim_sat((TW+1)'(roll_r) + stp);
        jtc_pkg::KEY_LX:    shut_nxt  = 1'b1;
        jtc_pkg::KEY_RX:    hold_nxt  = 1'b1;
        jtc_pkg::KEY_RX_LONG: begin
          pitch_nxt = '0;
          roll_nxt  = '0;
          cnt_nxt   = '0;
          cal_nxt   = 1'b1;
        end
      endcase
    end else if (smp && cal_r) begin
      if (last) begin
        cnt_nxt = '0;
        cal_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pitch_r <= '0;
      roll_r  <= '0;
      shut_r  <= 1'b0;
      hold_r  <= 1'b0;
      cal_r   <= 1'b0;
      cnt_r   <= '0;
      fin1_r  <= 1'b0;
      fin2_r  <= 1'b0;
    end else begin
      if (ld1) begin
        p1_v_r <= 1'b1;
      end else if (ld2) begin
        p1_v_r <= 1'b0;
      end
      if (ld2) begin
        p2_v_r <= 1'b1;
      end else if (proc) begin
        p2_v_r <= 1'b0;
      end
      if (smp) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      shut_r  <= shut_nxt;
      hold_r  <= hold_nxt;
      cal_r   <= cal_nxt;
      cnt_r   <= cnt_nxt;
      fin1_r  <= last;
      fin2_r  <= fin1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      p1_key_r  <= in_chan.req_type;
      p1_code_r <= jtc_pkg::key_code_t'(in_chan.key_code);
    end
    if (ld2) begin
      p2_key_r  <= p1_key_r;
      p2_code_r <= p1_code_r;
    end
    if (smp) begin
      out_val_r  <= lane_val;
      out_shut_r <= shut_r;
      out_hold_r <= hold_r;
      out_cal_r  <= cal_r;
    end
  end

  assign in_chan.ready             = in_ready;
  assign out_chan.valid            = out_v_r;
  assign out_chan.throttle_out     = out_val_r[jtc_pkg::LANE_THR];
  assign out_chan.yaw_out          = out_val_r[jtc_pkg::LANE_YAW];
  assign out_chan.pitch_out        = out_val_r[jtc_pkg::LANE_PIT];
  assign out_chan.roll_out         = out_val_r[jtc_pkg::LANE_ROL];
  assign out_chan.shutdown_flag    = out_shut_r;
  assign out_chan.hold_height_flag = out_hold_r;
  assign out_chan.calibrating      = out_cal_r;
  assign pitch_trim                = pitch_r;
  assign roll_trim                 = roll_r;

  assign trim_ok = (pitch_r <= TW'(jtc_pkg::LIMIT)) && (pitch_r >= -TW'(jtc_pkg::LIMIT)) &&
                   (roll_r <= TW'(jtc_pkg::LIMIT)) && (roll_r >= -TW'(jtc_pkg::LIMIT));

  `JTC_ASSERT_NEXT(a_fin_seq, fin1_r, fin2_r && !fin1_r && !cal_r, "Offset update broken.")
  `JTC_ASSERT(a_fin_quiet, !busy || (!cal_r && !proc), "Item processed during offset update.")
  `JTC_ASSERT_NEXT(a_sample_out, smp, out_v_r, "Processed sample left no result.")
  `JTC_ASSERT(a_cnt_range, cnt_r < CW'(CAL_SAMPLES), "Calibration count out of range.")
  `JTC_ASSERT(a_trim_range, trim_ok, "Trim beyond limit.")

endmodule

// File: hdl/joystick_trim_calibrate.sv
// Top level of the joystick trim and calibration block: APB register and lanes.
// Depends on jtc_pkg, jtc_in_if, jtc_out_if, jtc_lane and jtc_merge.
//
//  Channel   Direction  Handshake            Carries
//  in_chan   sink       valid/ready          sample readings or key event
//  out_chan  source     valid/ready          conditioned sticks and flags
//  cfg_*     slave      APB psel/penable     trim_step register
//
// One request is taken per cycle while nothing stalls; samples pass p1 and p2 to the result.
// The four lanes scale in two pipeline stages; state is read and written in the merge stage.
// The last calibration sample holds the merge stage through the fin1 and fin2 offset update.
// Synchronous reset clears control state at once, with no clearing pass; data is not reset.
// While the result waits, up to two more requests are buffered before in_chan.ready falls.
module joystick_trim_calibrate #(
  parameter int CAL_SAMPLES = 10,
  parameter int ADC_BITS    = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  jtc_in_if.sink                       in_chan,
  jtc_out_if.source                    out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [jtc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [jtc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [jtc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  logic [jtc_pkg::STEP_W-1:0]        trim_step_r;
  logic                              reg_hit;
  jtc_pkg::lane_ctl_t                ctl;
  logic signed [jtc_pkg::TRIM_W-1:0] pitch_trim, roll_trim;
  logic [ADC_BITS-1:0]               lane_adc   [jtc_pkg::NUM_LANES];
  logic signed [jtc_pkg::TRIM_W-1:0] lane_trim  [jtc_pkg::NUM_LANES];
  logic                              lane_ctr   [jtc_pkg::NUM_LANES];
  logic [jtc_pkg::VAL_W-1:0]         lane_val   [jtc_pkg::NUM_LANES];

  assign reg_hit    = (cfg_paddr[jtc_pkg::CFG_AW-1] == jtc_pkg::REG_TRIM_STEP);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? jtc_pkg::CFG_DW'(trim_step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_step_r <= jtc_pkg::STEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      trim_step_r <= cfg_pwdata[jtc_pkg::STEP_W-1:0];
    end
  end

  assign lane_adc[jtc_pkg::LANE_THR]  = in_chan.adc_throttle;
  assign lane_adc[jtc_pkg::LANE_YAW]  = in_chan.adc_yaw;
  assign lane_adc[jtc_pkg::LANE_PIT]  = in_chan.adc_pitch;
  assign lane_adc[jtc_pkg::LANE_ROL]  = in_chan.adc_roll;
  assign lane_trim[jtc_pkg::LANE_THR] = '0;
  assign lane_trim[jtc_pkg::LANE_YAW] = '0;
  assign lane_trim[jtc_pkg::LANE_PIT] = pitch_trim;
  assign lane_trim[jtc_pkg::LANE_ROL] = roll_trim;
  assign lane_ctr[jtc_pkg::LANE_THR]  = 1'b0;
  assign lane_ctr[jtc_pkg::LANE_YAW]  = 1'b1;
  assign lane_ctr[jtc_pkg::LANE_PIT]  = 1'b1;
  assign lane_ctr[jtc_pkg::LANE_ROL]  = 1'b1;

  for (genvar g = 0; g < jtc_pkg::NUM_LANES; g++) begin : g_lane
    jtc_lane #(
      .ADC_BITS    (ADC_BITS),
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .center_en (lane_ctr[g]),
      .adc       (lane_adc[g]),
      .trim      (lane_trim[g]),
      .val       (lane_val[g])
    );
  end

  jtc_merge #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .trim_step  (trim_step_r),
    .lane_val   (lane_val),
    .ctl        (ctl),
    .pitch_trim (pitch_trim),
    .roll_trim  (roll_trim)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for joystick_trim_calibrate: sends sample and key requests, writes the trim
// step over APB and checks every result against an internal prediction of the block.
// Depends on jtc_pkg, jtc_in_if, jtc_out_if and the joystick_trim_calibrate top level.
module testbench;

  localparam int CAL_RUN = 10;
  localparam int ADC_TOP = 4095;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIM = jtc_pkg::LIMIT;
  localparam int VW = jtc_pkg::VAL_W;
  localparam int AW = jtc_pkg::CFG_AW;
  localparam int DW = jtc_pkg::CFG_DW;
  localparam logic REQ_SAMPLE = ~jtc_pkg::REQ_KEY;
  localparam logic [AW-1:0] STEP_ADDR = AW'(4 * jtc_pkg::REG_TRIM_STEP);

  typedef struct packed {
    logic               req_type;
    logic [11:0]        thr;
    logic [11:0]        yaw;
    logic [11:0]        pit;
    logic [11:0]        rol;
    jtc_pkg::key_code_t key;
  } stick_req_t;

  typedef struct packed {
    logic [VW-1:0] thr;
    logic [VW-1:0] yaw;
    logic [VW-1:0] pit;
    logic [VW-1:0] rol;
    logic          shut;
    logic          hold;
    logic          cal;
  } stick_res_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [AW-1:0] cfg_paddr;
  logic [DW-1:0] cfg_pwdata;
  logic [DW-1:0] cfg_prdata;
  logic          cfg_pready;

  jtc_in_if #(.ADC_BITS(12)) in_chan ();
  jtc_out_if out_chan ();

  joystick_trim_calibrate #(.CAL_SAMPLES(CAL_RUN), .ADC_BITS(12)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  int zero_off[4] = '{default: 0};
  int cal_sum[4] = '{default: 0};
  int trim_pitch = 0;
  int trim_roll = 0;
  int cal_count = 0;
  bit cal_on = 1'b0;
  bit shut_latched = 1'b0;
  bit hold_latched = 1'b0;
  int trim_step = jtc_pkg::STEP_RESET;

  stick_res_t expected_q[$];
  bit failed = 1'b0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit predict_conditioning(input stick_req_t rq, output stick_res_t res);
    int raw[4];
    int val[4];
    res = '0;
    if (rq.req_type == jtc_pkg::REQ_KEY) begin
      if (cal_on) return 1'b0;
      case (rq.key)
        jtc_pkg::KEY_UP: trim_pitch = clip(trim_pitch + trim_step, -LIM, LIM);
        jtc_pkg::KEY_DN: trim_pitch = clip(trim_pitch - trim_step, -LIM, LIM);
        jtc_pkg::KEY_LT: trim_roll = clip(trim_roll - trim_step, -LIM, LIM);
        jtc_pkg::KEY_RT: trim_roll = clip(trim_roll + trim_step, -LIM, LIM);
        jtc_pkg::KEY_LX: shut_latched = 1'b1;
        jtc_pkg::KEY_RX: hold_latched = 1'b1;
        jtc_pkg::KEY_RX_LONG: begin
          trim_pitch = 0;
          trim_roll = 0;
          cal_sum = '{default: 0};
          cal_count = 0;
          cal_on = 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    raw = '{rq.thr, rq.yaw, rq.pit, rq.rol};
    for (int i = 0; i < jtc_pkg::NUM_LANES; i++) begin
      val[i] = jtc_pkg::SCALE_MAX - (raw[i] * jtc_pkg::SCALE_MAX) / ADC_TOP - zero_off[i];
      if (i == jtc_pkg::LANE_PIT) val[i] += trim_pitch;
      if (i == jtc_pkg::LANE_ROL) val[i] += trim_roll;
      val[i] = clip(val[i], 0, jtc_pkg::SCALE_MAX);
    end
    res.thr = VW'(val[jtc_pkg::LANE_THR]);
    res.yaw = VW'(val[jtc_pkg::LANE_YAW]);
    res.pit = VW'(val[jtc_pkg::LANE_PIT]);
    res.rol = VW'(val[jtc_pkg::LANE_ROL]);
    res.shut = shut_latched;
    res.hold = hold_latched;
    res.cal = cal_on;
    if (cal_on) begin
      for (int i = 0; i < jtc_pkg::NUM_LANES; i++) begin
        cal_sum[i] += val[i] - ((i == jtc_pkg::LANE_THR) ? 0 : jtc_pkg::CENTER);
      end
      cal_count++;
      if (cal_count >= CAL_RUN) begin
        for (int i = 0; i < jtc_pkg::NUM_LANES; i++) begin
          zero_off[i] = clip(zero_off[i] + cal_sum[i] / CAL_RUN, -LIM, LIM);
          cal_sum[i] = 0;
        end
        cal_count = 0;
        cal_on = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch_requests
    stick_req_t rq;
    stick_res_t res;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      rq.req_type = in_chan.req_type;
      rq.thr = in_chan.adc_throttle;
      rq.yaw = in_chan.adc_yaw;
      rq.pit = in_chan.adc_pitch;
      rq.rol = in_chan.adc_roll;
      rq.key = jtc_pkg::key_code_t'(in_chan.key_code);
      if (predict_conditioning(rq, res)) expected_q.push_back(res);
    end
  end

  task automatic compare_field(input string name, input logic [VW-1:0] want,
                               input logic [VW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : check_results
    stick_res_t got;
    stick_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = {out_chan.throttle_out, out_chan.yaw_out, out_chan.pitch_out, out_chan.roll_out,
             out_chan.shutdown_flag, out_chan.hold_height_flag, out_chan.calibrating};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        compare_field("throttle_out", want.thr, got.thr);
        compare_field("yaw_out", want.yaw, got.yaw);
        compare_field("pitch_out", want.pit, got.pit);
        compare_field("roll_out", want.rol, got.rol);
        compare_field("shutdown_flag", VW'(want.shut), VW'(got.shut));
        compare_field("hold_height_flag", VW'(want.hold), VW'(got.hold));
        compare_field("calibrating", VW'(want.cal), VW'(got.cal));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else begin
      out_chan.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [11:0] rand_adc();
    case ($urandom_range(0, 9))
      0: return 12'(0);
      1: return 12'(ADC_TOP);
      2: return 12'($urandom_range(1997, 2097));
      default: return 12'($urandom_range(0, ADC_TOP));
    endcase
  endfunction

  function automatic stick_req_t sample_req(input logic [11:0] thr, input logic [11:0] yaw,
                                            input logic [11:0] pit, input logic [11:0] rol);
    stick_req_t rq;
    rq.req_type = REQ_SAMPLE;
    rq.thr = thr;
    rq.yaw = yaw;
    rq.pit = pit;
    rq.rol = rol;
    rq.key = jtc_pkg::key_code_t'($urandom_range(int'(jtc_pkg::KEY_NONE),
                                                 int'(jtc_pkg::KEY_RX_LONG)));
    return rq;
  endfunction

  function automatic stick_req_t key_req(input jtc_pkg::key_code_t key);
    stick_req_t rq;
    rq = sample_req(12'($urandom_range(0, ADC_TOP)), 12'($urandom_range(0, ADC_TOP)),
                    12'($urandom_range(0, ADC_TOP)), 12'($urandom_range(0, ADC_TOP)));
    rq.req_type = jtc_pkg::REQ_KEY;
    rq.key = key;
    return rq;
  endfunction

  function automatic stick_req_t rand_sample();
    return sample_req(rand_adc(), rand_adc(), rand_adc(), rand_adc());
  endfunction

  function automatic jtc_pkg::key_code_t rand_key(input jtc_pkg::key_code_t fav_pitch,
                                                  input jtc_pkg::key_code_t fav_roll);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return fav_pitch;
    if (r < 60) return fav_roll;
    if (r < 88) begin
      return jtc_pkg::key_code_t'($urandom_range(int'(jtc_pkg::KEY_UP),
                                                 int'(jtc_pkg::KEY_RT)));
    end
    if (r < 92) return jtc_pkg::KEY_NONE;
    if (r < 96) return jtc_pkg::KEY_LX;
    return jtc_pkg::KEY_RX;
  endfunction

  task automatic send_request(input stick_req_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= rq.req_type;
    in_chan.adc_throttle <= rq.thr;
    in_chan.adc_yaw <= rq.yaw;
    in_chan.adc_pitch <= rq.pit;
    in_chan.adc_roll <= rq.rol;
    in_chan.key_code <= rq.key;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [DW-1:0] wdata,
                            output logic [DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= STEP_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_step_readback();
    logic [DW-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd !== DW'(trim_step)) begin
      $display("%0t: trim_step readback mismatch: expected %0d, actual %0d",
               $time, trim_step, rd);
      failed = 1'b1;
    end
  endtask

  task automatic run_random(input int count);
    int sent;
    jtc_pkg::key_code_t fav_pitch;
    jtc_pkg::key_code_t fav_roll;
    sent = 0;
    fav_pitch = $urandom_range(0, 1) ? jtc_pkg::KEY_UP : jtc_pkg::KEY_DN;
    fav_roll = $urandom_range(0, 1) ? jtc_pkg::KEY_RT : jtc_pkg::KEY_LT;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 4) begin
        send_request(key_req(jtc_pkg::KEY_RX_LONG));
        sent++;
        for (int i = 0; i < CAL_RUN + 2; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_request(key_req(rand_key(fav_pitch, fav_roll)));
          end else begin
            send_request(rand_sample());
          end
          sent++;
        end
      end else if ($urandom_range(0, 99) < 38) begin
        send_request(key_req(rand_key(fav_pitch, fav_roll)));
        sent++;
      end else begin
        send_request(rand_sample());
        sent++;
      end
    end
  endtask

  task automatic test_sample_extremes();
    send_request(sample_req(12'(0), 12'(0), 12'(0), 12'(0)));
    send_request(sample_req(12'(ADC_TOP), 12'(ADC_TOP), 12'(ADC_TOP), 12'(ADC_TOP)));
    send_request(sample_req(12'(ADC_TOP), 12'(0), 12'(2047), 12'(2048)));
    send_request(sample_req(12'(1), 12'(ADC_TOP - 1), 12'(2049), 12'(2046)));
  endtask

  task automatic test_keys();
    send_request(key_req(jtc_pkg::KEY_NONE));
    send_request(key_req(jtc_pkg::KEY_UP));
    send_request(key_req(jtc_pkg::KEY_UP));
    send_request(key_req(jtc_pkg::KEY_DN));
    send_request(key_req(jtc_pkg::KEY_LT));
    send_request(key_req(jtc_pkg::KEY_RT));
    send_request(key_req(jtc_pkg::KEY_RT));
    send_request(key_req(jtc_pkg::KEY_LX));
    send_request(key_req(jtc_pkg::KEY_RX));
    send_request(sample_req(12'(2047), 12'(2047), 12'(2047), 12'(2047)));
  endtask

  task automatic test_calibration();
    send_request(key_req(jtc_pkg::KEY_RX_LONG));
    repeat (CAL_RUN / 2) send_request(rand_sample());
    send_request(key_req(jtc_pkg::KEY_UP));
    repeat (CAL_RUN - CAL_RUN / 2) send_request(rand_sample());
    send_request(sample_req(12'(0), 12'(ADC_TOP), 12'(2047), 12'(0)));
  endtask

  task automatic test_step_settings();
    int steps[5];
    logic [DW-1:0] rd;
    steps = '{0, 127, 100, 1, $urandom_range(2, 99)};
    wait_idle();
    check_step_readback();
    foreach (steps[ph]) begin
      wait_idle();
      cfg_access(1'b1, DW'(steps[ph]), rd);
      trim_step = steps[ph] & 'h7f;
      check_step_readback();
      idle_on = (ph != 2);
      run_random(330);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = 1'b0;
    in_chan.adc_throttle = '0;
    in_chan.adc_yaw = '0;
    in_chan.adc_pitch = '0;
    in_chan.adc_roll = '0;
    in_chan.key_code = '0;
    out_chan.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_keys();
    test_calibration();
    test_step_settings();
    wait_idle();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/jtc_pkg.sv
hdl/jtc_in_if.sv
hdl/jtc_out_if.sv
hdl/jtc_lane.sv
hdl/jtc_merge.sv
hdl/joystick_trim_calibrate.sv
verif/testbench.sv
